// ===== rtl/svt_pkg.sv =====
// types and codes shared by the scoped variable table
// no dependencies
package svt_pkg;

  // entries per table
  localparam int MAX_VARS = 64;

  localparam logic [3:0] OP_ALLOC = 4'd0;
  localparam logic [3:0] OP_FIND_SCALAR = 4'd1;
  localparam logic [3:0] OP_FIND_ARRAY = 4'd2;
  localparam logic [3:0] OP_SET = 4'd3;
  localparam logic [3:0] OP_PUSH = 4'd4;
  localparam logic [3:0] OP_POP = 4'd5;
  localparam logic [3:0] OP_MARK_GLOBAL = 4'd6;
  localparam logic [3:0] OP_POP_GLOBAL = 4'd7;
  localparam logic [3:0] OP_CLEAR = 4'd8;
  localparam logic [3:0] OP_READ_FIRST = 4'd9;

  localparam logic [2:0] K_UNKNOWN = 3'd0;
  localparam logic [2:0] K_LONG = 3'd1;
  localparam logic [2:0] K_OBJ = 3'd2;
  localparam logic [2:0] K_REF = 3'd3;
  localparam logic [2:0] K_ARRAY = 3'd4;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_FRAMESFULL = 3'd3;
  localparam logic [2:0] ST_NOFRAME = 3'd4;
  localparam logic [2:0] ST_ISREF = 3'd5;
  localparam logic [2:0] ST_EMPTY = 3'd6;

  localparam logic [1:0] VK_LONG = 2'd0;
  localparam logic [1:0] VK_OBJ = 2'd1;
  localparam logic [1:0] VK_COPY = 2'd2;
  localparam logic [1:0] VK_REF = 2'd3;

  typedef struct packed {
    logic [3:0]  opcode;
    logic        is_global;
    logic        is_array;
    logic [15:0] var_id;
    logic [5:0]  slot;
    logic [1:0]  value_kind;
    logic [31:0] data_value;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        found_global;
    logic [5:0]  found_slot;
    logic [2:0]  entry_kind;
    logic [31:0] entry_value;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic take;        // latch the request, start
    logic scan_start;  // begin a lookup scan
    logic scan_step;   // advance scan one entry
    logic rd_issue;    // read entry at datapath read address
    logic exec;        // perform the final update
    logic deref;       // follow reference in read data
    logic rsp_load;    // load response register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_done;   // scan finished
    logic scan_hit;    // scan found a match
    logic is_copy;     // request is a copy set
    logic need_scan;   // request needs a lookup
    logic need_read;   // request needs an entry read
  } stat_t;

endpackage

// ===== rtl/svt_if.sv =====
// valid/ready channel carrying one payload
// depends on nothing
interface svt_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/svt_ctrl.sv =====
// sequencing state machine of the variable table
// depends on svt_pkg
module svt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  svt_pkg::stat_t  stat,
  output svt_pkg::cmd_t   cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DEREF = 3'd3;
  localparam logic [2:0] S_READ = 3'd4;
  localparam logic [2:0] S_EXEC = 3'd5;
  localparam logic [2:0] S_WAIT = 3'd6;

  logic [2:0] state, state_next;
  logic       rsp_full;

  assign in_ready = (state == S_IDLE);
  assign out_valid = rsp_full;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.need_scan) begin
          cmd.scan_start = 1'b1;
          state_next = S_SCAN;
        end else if (stat.need_read) begin
          cmd.rd_issue = 1'b1;
          state_next = S_READ;
        end else begin
          state_next = S_EXEC;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          if (stat.is_copy && stat.scan_hit) begin
            cmd.rd_issue = 1'b1;
            state_next = S_DEREF;
          end else begin
            cmd.rd_issue = stat.is_copy;
            state_next = stat.is_copy ? S_READ : S_EXEC;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_DEREF: begin
        cmd.deref = 1'b1;
        cmd.rd_issue = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        state_next = S_EXEC;
      end
      // finish only once the response register is free or being taken
      S_EXEC: begin
        if (!rsp_full || out_ready) begin
          cmd.exec = 1'b1;
          cmd.rsp_load = 1'b1;
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and response flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp_full <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.rsp_load) rsp_full <= 1'b1;
      else if (out_ready) rsp_full <= 1'b0;
    end
  end

endmodule

// ===== rtl/svt_dp.sv =====
// datapath: entry memories, counters, frame stack and scan pointer
// depends on svt_pkg
module svt_dp #(
  parameter int MAX_FRAMES = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  svt_pkg::req_t  req_in,
  input  svt_pkg::cmd_t  cmd,
  output svt_pkg::stat_t stat,
  output svt_pkg::rsp_t  rsp
);

  localparam int MAX_VARS = svt_pkg::MAX_VARS;
  localparam int AW = $clog2(MAX_VARS);
  localparam int CW = $clog2(MAX_VARS + 1);
  localparam int FW = $clog2(MAX_FRAMES);
  localparam int DW = $clog2(MAX_FRAMES + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_VARS);
  localparam logic [DW-1:0] FULL_DEPTH = DW'(MAX_FRAMES);

  // entry memory: address is {table, index}, table 1 is global
  logic [2:0]  kind_mem [2*MAX_VARS];
  logic [15:0] id_mem [2*MAX_VARS];
  logic [31:0] val_mem [2*MAX_VARS];

  logic [CW-1:0] frame_starts [MAX_FRAMES];
  logic [CW-1:0] local_count, global_count, global_frame_start;
  logic [DW-1:0] frame_depth;

  svt_pkg::req_t req;
  logic [2:0]  rd_kind;
  logic [15:0] rd_id;
  logic [31:0] rd_val;
  logic        ptr_tab;
  logic [CW-1:0] ptr_idx;
  logic [CW-1:0] scan_end;
  logic        hit, hit_tab;
  logic [AW-1:0] hit_idx;
  logic        rd_pend;
  logic [AW:0] rd_addr;

  logic [CW-1:0] cur_start;
  logic        has_frame;
  logic [15:0] want_id;
  logic        want_arr;
  logic        match;

  assign has_frame = frame_depth != '0;
  assign cur_start = frame_starts[FW'(frame_depth - DW'(1))];
  assign want_id = (req.opcode == svt_pkg::OP_SET) ? req.data_value[15:0] : req.var_id;
  assign want_arr = req.opcode == svt_pkg::OP_FIND_ARRAY;
  assign match = rd_pend && ((rd_kind == svt_pkg::K_ARRAY) == want_arr) && (rd_id == want_id);

  // status to the controller
  always_comb begin
    stat.need_scan = req.opcode == svt_pkg::OP_FIND_SCALAR ||
                     req.opcode == svt_pkg::OP_FIND_ARRAY ||
                     (req.opcode == svt_pkg::OP_SET && req.value_kind == svt_pkg::VK_COPY);
    stat.need_read = req.opcode == svt_pkg::OP_SET || req.opcode == svt_pkg::OP_READ_FIRST;
    stat.is_copy = req.opcode == svt_pkg::OP_SET && req.value_kind == svt_pkg::VK_COPY;
    stat.scan_hit = hit || match;
    stat.scan_done = !rd_pend && (hit || (ptr_tab && ptr_idx >= scan_end));
  end

  // memory read address; a copy source that is no reference is read again
  always_comb begin
    rd_addr = {ptr_tab, ptr_idx[AW-1:0]};
    if (cmd.deref && rd_kind == svt_pkg::K_REF)
      rd_addr = {rd_val[8], rd_val[AW-1:0] & AW'(8'hff)};
    else if (stat.is_copy && hit && !rd_pend) rd_addr = {hit_tab, hit_idx};
    else if (!stat.need_scan) begin
      if (req.opcode == svt_pkg::OP_READ_FIRST) rd_addr = {1'b0, cur_start[AW-1:0]};
      else rd_addr = {req.is_global, req.slot[AW-1:0]};
    end
  end

  // synchronous memory read; a match keeps the matching entry
  always_ff @(posedge clk) begin
    if (cmd.rd_issue || (cmd.scan_step && !match)) begin
      rd_kind <= kind_mem[rd_addr];
      rd_id <= id_mem[rd_addr];
      rd_val <= val_mem[rd_addr];
    end
  end

  // scan pointer over local frame then global frame
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      hit <= 1'b0;
    end else if (cmd.take) begin
      req <= req_in;
      rd_pend <= 1'b0;
      hit <= 1'b0;
    end else if (cmd.scan_start) begin
      hit <= 1'b0;
      rd_pend <= 1'b0;
      if (has_frame && cur_start < local_count) begin
        ptr_tab <= 1'b0;
        ptr_idx <= cur_start;
        scan_end <= local_count;
      end else begin
        ptr_tab <= 1'b1;
        ptr_idx <= global_frame_start;
        scan_end <= global_count;
      end
    end else if (cmd.scan_step) begin
      if (match) begin
        hit <= 1'b1;
        rd_pend <= 1'b0;
      end else if (!hit) begin
        if (!ptr_tab && ptr_idx >= scan_end) begin
          ptr_tab <= 1'b1;
          ptr_idx <= global_frame_start;
          scan_end <= global_count;
          rd_pend <= 1'b0;
        end else if (ptr_tab && ptr_idx >= scan_end) begin
          rd_pend <= 1'b0;
        end else begin
          hit_tab <= ptr_tab;
          hit_idx <= ptr_idx[AW-1:0];
          ptr_idx <= ptr_idx + CW'(1);
          rd_pend <= 1'b1;
        end
      end
    end else if (!cmd.rd_issue) begin
      if (match) hit <= 1'b1;
      rd_pend <= 1'b0;
    end
  end

  // final update and response
  logic [2:0]  new_kind;
  logic [31:0] new_val;
  logic        copy_ok;
  svt_pkg::rsp_t r;
  logic [CW-1:0] cnt_sel;

  assign copy_ok = hit && (rd_kind == svt_pkg::K_LONG || rd_kind == svt_pkg::K_OBJ);
  assign cnt_sel = req.is_global ? global_count : local_count;

  always_comb begin
    new_kind = svt_pkg::K_UNKNOWN;
    new_val = '0;
    case (req.value_kind)
      svt_pkg::VK_LONG: begin new_kind = svt_pkg::K_LONG; new_val = req.data_value; end
      svt_pkg::VK_OBJ: begin new_kind = svt_pkg::K_OBJ; new_val = req.data_value; end
      svt_pkg::VK_REF: begin new_kind = svt_pkg::K_REF; new_val = req.data_value; end
      default: begin
        if (copy_ok) begin new_kind = rd_kind; new_val = rd_val; end
      end
    endcase
    r = '0;
    case (req.opcode)
      svt_pkg::OP_ALLOC: begin
        if (cnt_sel >= FULL_CNT) r.status = svt_pkg::ST_FULL;
        else begin
          r.found_global = req.is_global;
          r.found_slot = 6'(cnt_sel);
          r.entry_kind = req.is_array ? svt_pkg::K_ARRAY : svt_pkg::K_UNKNOWN;
        end
      end
      svt_pkg::OP_FIND_SCALAR, svt_pkg::OP_FIND_ARRAY: begin
        if (!hit) r.status = svt_pkg::ST_NOTFOUND;
        else begin
          r.found_global = hit_tab;
          r.found_slot = 6'(hit_idx);
          r.entry_kind = rd_kind;
          r.entry_value = (rd_kind == svt_pkg::K_UNKNOWN || rd_kind == svt_pkg::K_ARRAY)
                          ? 32'd0 : rd_val;
        end
      end
      svt_pkg::OP_SET: begin
        if (!stat.is_copy && rd_kind == svt_pkg::K_REF) r.status = svt_pkg::ST_ISREF;
        else begin
          r.found_global = req.is_global;
          r.found_slot = 6'(req.slot[AW-1:0]);
          r.entry_kind = new_kind;
          r.entry_value = new_val;
        end
      end
      svt_pkg::OP_PUSH:
        if (frame_depth >= FULL_DEPTH) r.status = svt_pkg::ST_FRAMESFULL;
      svt_pkg::OP_POP:
        if (!has_frame) r.status = svt_pkg::ST_NOFRAME;
      svt_pkg::OP_READ_FIRST: begin
        if (!has_frame) r.status = svt_pkg::ST_NOFRAME;
        else if (local_count <= cur_start || cur_start >= FULL_CNT)
          r.status = svt_pkg::ST_EMPTY;
        else begin
          r.found_slot = 6'(cur_start);
          if (rd_kind == svt_pkg::K_LONG) begin
            r.entry_kind = svt_pkg::K_LONG;
            r.entry_value = rd_val;
          end
        end
      end
      default: r = '0;
    endcase
  end

  // copy set target kind is captured at scan start; hold it aside
  logic [2:0] tgt_kind;
  logic       tgt_ok;
  always_ff @(posedge clk) begin
    if (cmd.take) tgt_ok <= 1'b0;
    else if (cmd.scan_start) tgt_kind <= kind_mem[{req.is_global, req.slot[AW-1:0]}];
  end

  svt_pkg::rsp_t r_fix;
  always_comb begin
    r_fix = r;
    if (stat.is_copy && req.opcode == svt_pkg::OP_SET && tgt_kind == svt_pkg::K_REF)
      r_fix = '{status: svt_pkg::ST_ISREF, default: '0};
  end

  // state and memory update
  always_ff @(posedge clk) begin
    if (rst) begin
      local_count <= '0;
      global_count <= '0;
      global_frame_start <= '0;
      frame_depth <= DW'(1);
      frame_starts[0] <= '0;
    end else if (cmd.exec) begin
      case (req.opcode)
        svt_pkg::OP_ALLOC: begin
          if (cnt_sel < FULL_CNT) begin
            kind_mem[{req.is_global, cnt_sel[AW-1:0]}] <=
              req.is_array ? svt_pkg::K_ARRAY : svt_pkg::K_UNKNOWN;
            id_mem[{req.is_global, cnt_sel[AW-1:0]}] <= req.var_id;
            val_mem[{req.is_global, cnt_sel[AW-1:0]}] <= '0;
            if (req.is_global) global_count <= global_count + CW'(1);
            else local_count <= local_count + CW'(1);
          end
        end
        svt_pkg::OP_SET: begin
          if (r_fix.status == svt_pkg::ST_OK) begin
            kind_mem[{req.is_global, req.slot[AW-1:0]}] <= new_kind;
            val_mem[{req.is_global, req.slot[AW-1:0]}] <= new_val;
          end
        end
        svt_pkg::OP_PUSH: begin
          if (frame_depth < FULL_DEPTH) begin
            frame_starts[FW'(frame_depth)] <= local_count;
            frame_depth <= frame_depth + DW'(1);
          end
        end
        svt_pkg::OP_POP: begin
          if (has_frame) begin
            frame_depth <= frame_depth - DW'(1);
            local_count <= cur_start;
          end
        end
        svt_pkg::OP_MARK_GLOBAL: global_frame_start <= global_count;
        svt_pkg::OP_POP_GLOBAL: global_count <= global_frame_start;
        svt_pkg::OP_CLEAR: begin
          local_count <= '0;
          global_count <= '0;
          global_frame_start <= '0;
          frame_depth <= DW'(1);
          frame_starts[0] <= '0;
        end
        default: ;
      endcase
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (cmd.rsp_load) rsp <= tgt_ok ? r : r_fix;
  end

endmodule

// ===== rtl/scoped_variable_table_unit.sv =====
// top level of the scoped variable table: controller plus datapath
// depends on svt_pkg, svt_if, svt_ctrl, svt_dp
//
//  channel  dir  payload
//  req      in   opcode, is_global, is_array, var_id, slot, value_kind, data_value
//  rsp      out  status, found_global, found_slot, entry_kind, entry_value
//
// one request at a time; a lookup reads one table entry per cycle from the
// entry memory, over the local frame and then the global frame.
// reset clears counters and leaves one frame; entry memory is not cleared.
// the next request is taken while a response waits; it holds in its last
// step until the waiting response is taken.
module scoped_variable_table_unit #(
  parameter int MAX_FRAMES = 8
) (
  input logic clk,
  input logic rst,
  svt_if.sink   req,
  svt_if.source rsp
);

  svt_pkg::cmd_t  cmd;
  svt_pkg::stat_t stat;

  svt_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .stat(stat), .cmd(cmd)
  );

  svt_dp #(.MAX_FRAMES(MAX_FRAMES)) u_dp (
    .clk(clk), .rst(rst),
    .req_in(req.data), .cmd(cmd), .stat(stat), .rsp(rsp.data)
  );

endmodule
